/* hdl/abg_tracker_decaying_gain_assert.svh */
// Assertion macros for the alpha-beta-gamma tracker.
// Included by the top level; no other dependencies.
`ifndef ABG_TRACKER_DECAYING_GAIN_ASSERT_SVH
`define ABG_TRACKER_DECAYING_GAIN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ABG_ASSERT_IMP(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("tracker check failed");

// Next-cycle implication, disabled during reset.
`define ABG_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("tracker check failed");

`endif

/* hdl/abg_pkg.sv */
// Shared types and constants for the alpha-beta-gamma tracker.
// No dependencies; used by the shared arithmetic unit and the top level.
package abg_pkg;

  localparam int MEAS_WIDTH      = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int TIME_WIDTH      = 16;
  localparam int ERR_WIDTH       = 16;
  localparam int REG_WIDTH       = 32;
  localparam int GAIN_WIDTH      = 33;
  localparam int GAIN_SHIFT      = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int STEP_WIDTH      = 7;

  localparam int MOTION_DEF = (MEAS_WIDTH + FRAC_BITS_DEF > 62) ? 62
                                                               : MEAS_WIDTH + FRAC_BITS_DEF;
  localparam int UNC_DEF    = 2 * ERR_WIDTH + FRAC_BITS_DEF;
  localparam int OPA_DEF    = UNC_DEF + GAIN_SHIFT;
  localparam int OPB_DEF    = UNC_DEF + 1;
  localparam int RES_DEF    = ((MOTION_DEF > UNC_DEF) ? MOTION_DEF : UNC_DEF) + GAIN_WIDTH;

  localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = {1'b1, {GAIN_SHIFT{1'b0}}};

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MEAS_ERR = 2'd0,
    REG_INIT_VEL = 2'd1,
    REG_INIT_ACC = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic                  start;
    mdu_op_t               op;
    logic [STEP_WIDTH-1:0] steps;
  } mdu_ctrl_t;

  typedef struct packed {
    logic                         operation;
    logic [TIME_WIDTH-1:0]        time_delta;
    logic signed [MEAS_WIDTH-1:0] measurement;
  } abg_in_t;

  typedef struct packed {
    logic signed [MEAS_WIDTH-1:0] position;
    logic                         bad_time;
  } abg_out_t;

endpackage

/* hdl/abg_tracker_decaying_gain.sv */
// Alpha-beta-gamma tracker with decaying gains: one axis, fixed point, saturating.
// Restart and zero-time updates go from S_LOAD straight to S_OUT, which loads the result.
// An update runs 14 operations (13 when U+R is zero) on one bit-serial multiply/divide
// unit; a new item is not taken until the result of the last one has been loaded.
// Synchronous active-high reset clears the estimates and gains to zero, meas_err to 5.
// Depends on abg_pkg, abg_mdu and abg_tracker_decaying_gain_assert.svh.
`include "abg_tracker_decaying_gain_assert.svh"

module abg_tracker_decaying_gain import abg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  abg_in_t                    in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output abg_out_t                   out_data,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0]       cfg_data
);

  localparam int MW  = (MEAS_WIDTH + FRAC_BITS > 62) ? 62 : MEAS_WIDTH + FRAC_BITS;
  localparam int UW  = 2 * ERR_WIDTH + FRAC_BITS;
  localparam int DW  = UW + 1;
  localparam int AW  = (MW > UW) ? MW : UW;
  localparam int NW  = UW + GAIN_SHIFT;
  localparam int VW  = DW;
  localparam int RW  = AW + GAIN_WIDTH;
  localparam int SW  = MW + 34;
  localparam int UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DN  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  localparam logic [STEP_WIDTH-1:0] STEPS_K    = STEP_WIDTH'(NW);
  localparam logic [STEP_WIDTH-1:0] STEPS_GAIN = STEP_WIDTH'(GAIN_WIDTH);
  localparam logic [STEP_WIDTH-1:0] STEPS_T    = STEP_WIDTH'(TIME_WIDTH);
  localparam logic [STEP_WIDTH-1:0] STEPS_TT   = STEP_WIDTH'(2 * TIME_WIDTH);
  localparam logic [STEP_WIDTH-1:0] STEPS_DB   = STEP_WIDTH'(MW + 1);
  localparam logic [STEP_WIDTH-1:0] STEPS_DG   = STEP_WIDTH'(MW + 2);

  localparam logic signed [SW-1:0] SAT_MAX = {{(SW - MW + 1){1'b0}}, {(MW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW - MW + 1){1'b1}}, {(MW - 1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_KDIV, S_UMUL, S_GA, S_GB, S_GG, S_AT, S_TT, S_HALF,
    S_VT, S_RES, S_PA, S_PB, S_DB, S_PG, S_DG, S_OUT
  } state_t;

  function automatic logic signed [MW-1:0] sat_mw(input logic signed [SW-1:0] x);
    if (x > SAT_MAX) return SAT_MAX[MW-1:0];
    if (x < SAT_MIN) return SAT_MIN[MW-1:0];
    return x[MW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [MW-1:0] v);
    return {{(SW - MW){v[MW-1]}}, v};
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
    return v[MW-1] ? -v : v;
  endfunction

  function automatic logic signed [SW-1:0] term(input logic neg, input logic [SW-1:0] u);
    return neg ? -$signed(u) : $signed(u);
  endfunction

  function automatic logic [SW-1:0] to_sw(input logic [RW-1:0] x);
    logic [RW+SW-1:0] w;
    w = {{SW{1'b0}}, x};
    return w[SW-1:0];
  endfunction

  // Q16.16 register to the internal motion format.
  function automatic logic signed [MW-1:0] from_q16(input logic [REG_WIDTH-1:0] r);
    logic signed [SW-1:0] e;
    logic [SW-1:0]        m;
    e = {{(SW - REG_WIDTH){r[REG_WIDTH-1]}}, r};
    m = e[SW-1] ? -e : e;
    if (FRAC_BITS >= 16) return sat_mw(e <<< UP);
    return sat_mw(term(e[SW-1], m >> DN));
  endfunction

  function automatic logic [MEAS_WIDTH-1:0] pos_of(input logic signed [MW-1:0] p);
    logic [MW-1:0]            m;
    logic [MW+MEAS_WIDTH-1:0] w;
    m = mag(p) >> FRAC_BITS;
    w = {{MEAS_WIDTH{1'b0}}, m};
    w = p[MW-1] ? -w : w;
    return w[MEAS_WIDTH-1:0];
  endfunction

  state_t                   state;
  logic                     issued;
  logic                     op_r;
  logic [TIME_WIDTH-1:0]    t_r;
  logic [MEAS_WIDTH-1:0]    meas_r;
  logic [ERR_WIDTH-1:0]     meas_err;
  logic [REG_WIDTH-1:0]     init_velocity;
  logic [REG_WIDTH-1:0]     init_acceleration;
  logic signed [MW-1:0]     est_p, est_v, est_a;
  logic [UW-1:0]            unc;
  logic [2*ERR_WIDTH-1:0]   nvar;
  logic [GAIN_WIDTH-1:0]    ga, gb, gg, k;
  logic signed [MW-1:0]     mq, pv, pp;
  logic [2*TIME_WIDTH-1:0]  tt;
  logic signed [SW-1:0]     hterm;
  logic                     r_neg, bad;
  logic [MW-1:0]            rm;
  logic [MW:0]              bq;
  logic [MW+1:0]            gq;

  mdu_ctrl_t                ctrl;
  logic [NW-1:0]            opa;
  logic [VW-1:0]            opb;
  logic                     mdu_done;
  logic [RW-1:0]            mres;

  logic signed [MW-1:0]     mq_c;
  logic [2*ERR_WIDTH-1:0]   nvar_c;
  logic [DW-1:0]            d_c;
  logic [SW-1:0]            mres_sw;
  logic [RW-1:0]            mres_sh32;
  logic [RW-1:0]            mres_sh31;
  logic signed [MW:0]       r_full;
  logic [MW:0]              r_mag;
  logic                     in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign mq_c      = sat_mw({{(SW - MEAS_WIDTH){meas_r[MEAS_WIDTH-1]}}, meas_r} <<< FRAC_BITS);
  assign nvar_c    = meas_err * meas_err;
  assign d_c       = {1'b0, unc} + {1'b0, nvar, {FRAC_BITS{1'b0}}};
  assign mres_sw   = to_sw(mres);
  assign mres_sh32 = mres >> GAIN_SHIFT;
  assign mres_sh31 = mres >> (GAIN_SHIFT - 1);
  assign r_full    = {mq[MW-1], mq} - {pp[MW-1], pp};
  assign r_mag     = r_full[MW] ? -r_full : r_full;

  // Operand select for the shared unit.
  always_comb begin
    ctrl       = '0;
    ctrl.start = !issued;
    opa        = '0;
    opb        = '0;
    unique case (state)
      S_KDIV: begin
        ctrl.op = MDU_DIV;  ctrl.steps = STEPS_K;
        opa = {unc, {GAIN_SHIFT{1'b0}}};
        opb = d_c;
      end
      S_UMUL: begin
        ctrl.op = MDU_MUL;  ctrl.steps = STEPS_GAIN;
        opa = NW'(unc);
        opb = VW'(GAIN_ONE - k);
      end
      S_GA, S_GB, S_GG: begin
        ctrl.op = MDU_MUL;  ctrl.steps = STEPS_GAIN;
        opa = (state == S_GA) ? NW'(ga) : (state == S_GB) ? NW'(gb) : NW'(gg);
        opb = VW'(k);
      end
      S_AT: begin
        ctrl.op = MDU_MUL;  ctrl.steps = STEPS_T;
        opa = NW'(mag(est_a));
        opb = VW'(t_r);
      end
      S_TT: begin
        ctrl.op = MDU_MUL;  ctrl.steps = STEPS_T;
        opa = NW'(t_r);
        opb = VW'(t_r);
      end
      S_HALF: begin
        ctrl.op = MDU_MUL;  ctrl.steps = STEPS_TT;
        opa = NW'(mag(est_a));
        opb = VW'(tt);
      end
      S_VT: begin
        ctrl.op = MDU_MUL;  ctrl.steps = STEPS_T;
        opa = NW'(mag(est_v));
        opb = VW'(t_r);
      end
      S_PA, S_PB, S_PG: begin
        ctrl.op = MDU_MUL;  ctrl.steps = STEPS_GAIN;
        opa = NW'(rm);
        opb = (state == S_PA) ? VW'(ga) : (state == S_PB) ? VW'(gb) : VW'(gg);
      end
      S_DB: begin
        ctrl.op = MDU_DIV;  ctrl.steps = STEPS_DB;
        opa = NW'(bq) << (NW - MW - 1);
        opb = VW'(t_r);
      end
      S_DG: begin
        ctrl.op = MDU_DIV;  ctrl.steps = STEPS_DG;
        opa = NW'(gq) << (NW - MW - 2);
        opb = VW'(tt);
      end
      default: ctrl.start = 1'b0;
    endcase
  end

  abg_mdu #(
    .A_WIDTH (NW),
    .B_WIDTH (VW),
    .R_WIDTH (RW)
  ) u_mdu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .opa    (opa),
    .opb    (opb),
    .done   (mdu_done),
    .result (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      issued            <= 1'b0;
      out_valid         <= 1'b0;
      meas_err          <= ERR_WIDTH'(5);
      init_velocity     <= '0;
      init_acceleration <= '0;
      est_p             <= '0;
      est_v             <= '0;
      est_a             <= '0;
      unc               <= '0;
      nvar              <= '0;
      ga                <= '0;
      gb                <= '0;
      gg                <= '0;
      k                 <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MEAS_ERR: meas_err          <= cfg_data[ERR_WIDTH-1:0];
          REG_INIT_VEL: init_velocity     <= cfg_data;
          REG_INIT_ACC: init_acceleration <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && (state != S_OUT)) out_valid <= 1'b0;

      if (ctrl.start) issued <= 1'b1;
      if (mdu_done)   issued <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_r   <= in_data.operation;
            t_r    <= in_data.time_delta;
            meas_r <= in_data.measurement;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          mq  <= mq_c;
          bad <= 1'b0;
          if (op_r == OP_RESTART) begin
            est_p <= mq_c;
            est_v <= from_q16(init_velocity);
            est_a <= from_q16(init_acceleration);
            nvar  <= nvar_c;
            unc   <= {nvar_c, {FRAC_BITS{1'b0}}};
            ga    <= GAIN_ONE;
            gb    <= GAIN_ONE;
            gg    <= GAIN_ONE;
            state <= S_OUT;
          end else if (t_r == '0) begin
            bad   <= 1'b1;
            state <= S_OUT;
          end else if (d_c == '0) begin
            k     <= '0;
            state <= S_UMUL;
          end else begin
            state <= S_KDIV;
          end
        end
        S_KDIV: if (mdu_done) begin
          k     <= mres[GAIN_WIDTH-1:0];
          state <= S_UMUL;
        end
        S_UMUL: if (mdu_done) begin
          unc   <= mres[UW+GAIN_SHIFT-1:GAIN_SHIFT];
          state <= S_GA;
        end
        S_GA: if (mdu_done) begin
          ga    <= mres_sh32[GAIN_WIDTH-1:0];
          state <= S_GB;
        end
        S_GB: if (mdu_done) begin
          gb    <= mres_sh32[GAIN_WIDTH-1:0];
          state <= S_GG;
        end
        S_GG: if (mdu_done) begin
          gg    <= mres_sh32[GAIN_WIDTH-1:0];
          state <= S_AT;
        end
        S_AT: if (mdu_done) begin
          pv    <= sat_mw(ext(est_v) + term(est_a[MW-1], mres_sw));
          state <= S_TT;
        end
        S_TT: if (mdu_done) begin
          tt    <= mres[2*TIME_WIDTH-1:0];
          state <= S_HALF;
        end
        S_HALF: if (mdu_done) begin
          hterm <= term(est_a[MW-1], mres_sw >> 1);
          state <= S_VT;
        end
        S_VT: if (mdu_done) begin
          pp    <= sat_mw(ext(est_p) + term(est_v[MW-1], mres_sw) + hterm);
          state <= S_RES;
        end
        S_RES: begin
          r_neg <= r_full[MW];
          rm    <= r_mag[MW-1:0];
          state <= S_PA;
        end
        S_PA: if (mdu_done) begin
          est_p <= sat_mw(ext(pp) + term(r_neg, to_sw(mres_sh32)));
          state <= S_PB;
        end
        S_PB: if (mdu_done) begin
          bq    <= mres_sh32[MW:0];
          state <= S_DB;
        end
        S_DB: if (mdu_done) begin
          est_v <= sat_mw(ext(pv) + term(r_neg, mres_sw));
          state <= S_PG;
        end
        S_PG: if (mdu_done) begin
          gq    <= mres_sh31[MW+1:0];
          state <= S_DG;
        end
        S_DG: if (mdu_done) begin
          est_a <= sat_mw(ext(est_a) + term(r_neg, mres_sw));
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            out_data.position <= pos_of(est_p);
            out_data.bad_time <= bad;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ABG_ASSERT_IMP(a_done_issued, clk, rst, mdu_done, issued)
  `ABG_ASSERT_IMP(a_gain_range, clk, rst, 1'b1, (ga <= GAIN_ONE) && (gb <= GAIN_ONE) && (gg <= GAIN_ONE))
  `ABG_ASSERT_IMP(a_k_range, clk, rst, state == S_UMUL, k <= GAIN_ONE)
  `ABG_ASSERT_NEXT(a_out_load, clk, rst, (state == S_OUT) && !out_valid, out_valid)

endmodule

/* hdl/abg_mdu.sv */
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
// Depends on abg_pkg for the control struct and operation codes.
module abg_mdu import abg_pkg::*; #(
  parameter int A_WIDTH = OPA_DEF,
  parameter int B_WIDTH = OPB_DEF,
  parameter int R_WIDTH = RES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mdu_ctrl_t          ctrl,
  input  logic [A_WIDTH-1:0] opa,
  input  logic [B_WIDTH-1:0] opb,
  output logic               done,
  output logic [R_WIDTH-1:0] result
);

  logic                  busy;
  mdu_op_t               op_r;
  logic [STEP_WIDTH-1:0] count;
  logic [R_WIDTH-1:0]    acc;
  logic [R_WIDTH-1:0]    mcand;
  logic [B_WIDTH-1:0]    bsh;
  logic [B_WIDTH:0]      rem;

  logic [R_WIDTH-1:0]    acc_next;
  logic [R_WIDTH-1:0]    mcand_next;
  logic [B_WIDTH-1:0]    bsh_next;
  logic [B_WIDTH:0]      rem_next;
  logic [B_WIDTH:0]      rem_sh;
  logic                  ge;
  logic [A_WIDTH-1:0]    quot_next;

  // Multiply: add the shifted multiplicand per set multiplier bit.
  // Divide: dividend arrives left-aligned in mcand; quotient bits shift in at the bottom.
  always_comb begin
    acc_next   = acc;
    mcand_next = mcand;
    bsh_next   = bsh;
    rem_next   = rem;
    rem_sh     = {rem[B_WIDTH-1:0], mcand[A_WIDTH-1]};
    ge         = (rem_sh >= {1'b0, bsh});
    quot_next  = {mcand[A_WIDTH-2:0], ge};
    case (op_r)
      MDU_MUL: begin
        acc_next   = acc + (bsh[0] ? mcand : '0);
        mcand_next = mcand << 1;
        bsh_next   = bsh >> 1;
      end
      default: begin
        rem_next   = ge ? (rem_sh - {1'b0, bsh}) : rem_sh;
        mcand_next = {{(R_WIDTH - A_WIDTH){1'b0}}, quot_next};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
      op_r  <= MDU_MUL;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy  <= 1'b1;
        op_r  <= ctrl.op;
        count <= ctrl.steps;
        acc   <= '0;
        mcand <= {{(R_WIDTH - A_WIDTH){1'b0}}, opa};
        bsh   <= opb;
        rem   <= '0;
      end else if (busy) begin
        acc   <= acc_next;
        mcand <= mcand_next;
        bsh   <= bsh_next;
        rem   <= rem_next;
        count <= count - 1'b1;
        if (count == STEP_WIDTH'(1)) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= (op_r == MDU_MUL) ? acc_next : mcand_next;
        end
      end
    end
  end

endmodule
